// ===== design/length_prefixed_frame_extractor_core_defines.svh =====
// Assertion helpers; expect i_clk and i_rst_n in the enclosing module.
`ifndef LENGTH_PREFIXED_FRAME_EXTRACTOR_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication
`define LPFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lpfe_pkg.sv =====
package lpfe_pkg;

    localparam int MAX_PAYLOAD   = 512;
    localparam int LENGTH_DIGITS = 4;

    localparam int BYTE_W = 8;
    localparam int ACC_W  = 14;
    localparam int DIG_W  = 3;
    localparam int BL_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int ERR_W  = 2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ERR_W-1:0]  t_err;

    localparam t_err ERR_NONE     = 2'd0;
    localparam t_err ERR_NONDIGIT = 2'd1;
    localparam t_err ERR_TOO_LONG = 2'd2;

    typedef struct packed {
        t_byte payload_byte;
        logic  payload_valid;
        logic  frame_last;
        t_err  error_code;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_step;

endpackage

// ===== design/lpfe_byte_if.sv =====
interface lpfe_byte_if;
    logic           valid;
    logic           ready;
    lpfe_pkg::t_byte stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== design/lpfe_frame_if.sv =====
interface lpfe_frame_if;
    logic            valid;
    logic            ready;
    lpfe_pkg::t_byte payload_byte;
    logic            payload_valid;
    logic            frame_last;
    lpfe_pkg::t_err  error_code;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_last, output error_code, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_last, input error_code, output ready);
endinterface

// ===== design/lpfe_cfg_if.sv =====
interface lpfe_cfg_if;
    logic            valid;
    logic            ready;
    lpfe_pkg::t_byte data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/lpfe_in_stage.sv =====
module lpfe_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lpfe_byte_if.sink       i_in,
    input  logic            i_take,
    output logic            o_valid,
    output lpfe_pkg::t_byte o_byte
);

    logic            r_valid;
    lpfe_pkg::t_byte r_byte;
    logic            accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.stream_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== design/lpfe_parser.sv =====
`include "length_prefixed_frame_extractor_core_defines.svh"

module lpfe_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  lpfe_pkg::t_byte i_byte,
    input  lpfe_pkg::t_byte i_head_byte,
    output lpfe_pkg::t_step o_step
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    localparam logic [lpfe_pkg::ACC_W-1:0] MAX_LEN =
        lpfe_pkg::ACC_W'(lpfe_pkg::MAX_PAYLOAD);
    localparam logic [lpfe_pkg::DIG_W-1:0] NUM_DIGITS =
        lpfe_pkg::DIG_W'(lpfe_pkg::LENGTH_DIGITS);

    logic [1:0]                  r_phase, n_phase;
    logic [lpfe_pkg::DIG_W-1:0]  r_digits, n_digits;
    logic [lpfe_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [lpfe_pkg::BL_W-1:0]   r_left, n_left;

    logic                        is_digit;
    logic [lpfe_pkg::ACC_W-1:0]  acc_x10;
    logic [lpfe_pkg::ACC_W-1:0]  acc_new;
    logic [lpfe_pkg::DIG_W-1:0]  digits_new;
    lpfe_pkg::t_step             step;

    assign is_digit   = i_byte inside {[8'h30:8'h39]};
    assign acc_x10    = {r_acc[lpfe_pkg::ACC_W-4:0], 3'b000}
                      + {r_acc[lpfe_pkg::ACC_W-2:0], 1'b0};
    assign acc_new    = acc_x10 + {{(lpfe_pkg::ACC_W-4){1'b0}}, i_byte[3:0]};
    assign digits_new = r_digits + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_acc    = r_acc;
        n_left   = r_left;
        step     = '0;
        if (i_advance) begin
            case (r_phase)
                PH_LEN: begin
                    if (!is_digit) begin
                        n_phase  = PH_HUNT;
                        n_digits = '0;
                        n_acc    = '0;
                        n_left   = '0;
                        step.valid          = 1'b1;
                        step.res.error_code = lpfe_pkg::ERR_NONDIGIT;
                    end else if (digits_new < NUM_DIGITS) begin
                        n_digits = digits_new;
                        n_acc    = acc_new;
                    end else if (acc_new > MAX_LEN) begin
                        n_phase  = PH_HUNT;
                        n_digits = '0;
                        n_acc    = '0;
                        n_left   = '0;
                        step.valid          = 1'b1;
                        step.res.error_code = lpfe_pkg::ERR_TOO_LONG;
                    end else if (acc_new == '0) begin
                        n_phase  = PH_HUNT;
                        n_digits = '0;
                        n_acc    = '0;
                        n_left   = '0;
                        step.valid          = 1'b1;
                        step.res.frame_last = 1'b1;
                    end else begin
                        n_phase  = PH_PAY;
                        n_digits = digits_new;
                        n_acc    = acc_new;
                        n_left   = acc_new[lpfe_pkg::BL_W-1:0];
                    end
                end
                PH_PAY: begin
                    if (r_left != '0) begin
                        step.valid             = 1'b1;
                        step.res.payload_byte  = i_byte;
                        step.res.payload_valid = 1'b1;
                        step.res.frame_last    = (r_left == 1);
                        if (r_left == 1) begin
                            n_phase  = PH_HUNT;
                            n_digits = '0;
                            n_acc    = '0;
                            n_left   = '0;
                        end else begin
                            n_left = r_left - 1'b1;
                        end
                    end else begin
                        n_phase  = (i_byte == i_head_byte) ? PH_LEN : PH_HUNT;
                        n_digits = '0;
                        n_acc    = '0;
                        n_left   = '0;
                    end
                end
                default: begin
                    n_phase  = (i_byte == i_head_byte) ? PH_LEN : PH_HUNT;
                    n_digits = '0;
                    n_acc    = '0;
                    n_left   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_digits <= '0;
            r_acc    <= '0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_acc    <= n_acc;
            r_left   <= n_left;
        end
    end

    assign o_step = step;

    `LPFE_ASSERT_NOW(a_pay_has_bytes, r_phase == PH_PAY, r_left != '0,
        "payload phase with no bytes left")
    `LPFE_ASSERT_NOW(a_len_digit_range, r_phase == PH_LEN, r_digits < NUM_DIGITS,
        "length phase past digit count")
    `LPFE_ASSERT_NOW(a_hunt_clear, r_phase == PH_HUNT,
        r_left == '0 && r_digits == '0 && r_acc == '0, "hunt state not cleared")
    `LPFE_ASSERT_NEXT(a_last_to_hunt, i_advance && r_phase == PH_PAY && r_left == 1,
        r_phase == PH_HUNT, "no return to hunt after last beat")

endmodule

// ===== design/lpfe_out_stage.sv =====
module lpfe_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  lpfe_pkg::t_step i_step,
    output logic            o_can_take,
    lpfe_frame_if.source    o_out
);

    logic             r_valid;
    lpfe_pkg::t_result r_res;

    assign o_can_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance && i_step.valid) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_step.valid) begin
            r_res <= i_step.res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.payload_byte  = r_res.payload_byte;
    assign o_out.payload_valid = r_res.payload_valid;
    assign o_out.frame_last    = r_res.frame_last;
    assign o_out.error_code    = r_res.error_code;

endmodule

// ===== design/length_prefixed_frame_extractor_core.sv =====
// Byte-stream deframer: drops bytes until the head byte (cfg register, reset 0)
// is seen, reads four ASCII decimal length digits, then passes that many
// payload bytes with frame_last on the final one. A bad digit gives a beat with
// error_code 1, a length above 512 gives error_code 2, a zero length gives one
// empty beat with frame_last set; each returns to hunting. One byte is taken
// per clock when neither side stalls; a beat is offered once its byte has
// passed the input register and its parse result has been captured in the
// result register, and both sides may stall freely.
module length_prefixed_frame_extractor_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpfe_cfg_if.sink     i_cfg,
    lpfe_byte_if.sink    i_in,
    lpfe_frame_if.source o_out
);

    lpfe_pkg::t_byte r_head_byte;
    logic            in_valid;
    lpfe_pkg::t_byte in_byte;
    logic            out_can_take;
    logic            advance;
    lpfe_pkg::t_step step;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte <= '0;
        end else if (i_cfg.valid) begin
            r_head_byte <= i_cfg.data;
        end
    end

    assign advance = in_valid && out_can_take;

    lpfe_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    lpfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (in_byte),
        .i_head_byte (r_head_byte),
        .o_step      (step)
    );

    lpfe_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_step     (step),
        .o_can_take (out_can_take),
        .o_out      (o_out)
    );

endmodule

// ===== test/tb_length_prefixed_frame_extractor_core.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_frame_extractor_core;

    localparam int              CLK_HALF    = 5;
    localparam int              RST_CYCLES  = 5;
    localparam int              DRAIN_SLACK = 8;
    localparam int              HOLD_CYCLES = 400;
    localparam int              CYCLE_LIMIT = 200000;
    localparam int              RAND_ITEMS  = 333;
    localparam lpfe_pkg::t_byte ASCII_ZERO  = 8'h30;
    localparam lpfe_pkg::t_byte ASCII_NINE  = 8'h39;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpfe_cfg_if   cfg_if ();
    lpfe_byte_if  in_if ();
    lpfe_frame_if out_if ();

    length_prefixed_frame_extractor_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    lpfe_pkg::t_byte   byte_q[$];
    lpfe_pkg::t_result frame_q[$];

    int   src_idle_pct;
    int   snk_idle_pct;
    logic hold_rx;

    // deframer state mirror
    logic [1:0]                 pp;
    logic [lpfe_pkg::DIG_W-1:0] dig_cnt;
    logic [lpfe_pkg::ACC_W-1:0] len_acc;
    logic [lpfe_pkg::BL_W-1:0]  left;
    lpfe_pkg::t_byte            head_cfg;
    lpfe_pkg::t_byte            last_head;

    int n_fail      = 0;
    int n_beats     = 0;
    int n_frames    = 0;
    int n_digit_err = 0;
    int n_len_err   = 0;
    int n_cycles    = 0;

    lpfe_pkg::t_result got_exp;

    task automatic deframe_byte(input lpfe_pkg::t_byte b);
        lpfe_pkg::t_result r;
        logic              has_beat;
        r = '0;
        has_beat = 1'b0;
        if (pp == PH_LEN) begin
            if (b < ASCII_ZERO || b > ASCII_NINE) begin
                has_beat = 1'b1;
                r.error_code = lpfe_pkg::ERR_NONDIGIT;
                pp = PH_HUNT;
            end else begin
                len_acc = len_acc * 14'd10 + lpfe_pkg::ACC_W'(b - ASCII_ZERO);
                dig_cnt = dig_cnt + 1'b1;
                if (dig_cnt == lpfe_pkg::LENGTH_DIGITS) begin
                    if (len_acc > lpfe_pkg::MAX_PAYLOAD) begin
                        has_beat = 1'b1;
                        r.error_code = lpfe_pkg::ERR_TOO_LONG;
                        pp = PH_HUNT;
                    end else if (len_acc == 0) begin
                        has_beat = 1'b1;
                        r.frame_last = 1'b1;
                        pp = PH_HUNT;
                    end else begin
                        left = lpfe_pkg::BL_W'(len_acc);
                        pp = PH_PAY;
                    end
                end
            end
        end else if (pp == PH_PAY && left != 0) begin
            has_beat = 1'b1;
            r.payload_byte = b;
            r.payload_valid = 1'b1;
            r.frame_last = (left == 1);
            left = left - 1'b1;
            if (left == 0) begin
                pp = PH_HUNT;
            end
        end else begin
            dig_cnt = '0;
            len_acc = '0;
            left = '0;
            pp = (b == head_cfg) ? PH_LEN : PH_HUNT;
        end
        if (has_beat) begin
            frame_q.push_back(r);
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.stream_byte <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                deframe_byte(in_if.stream_byte);
            end
            if (!in_if.valid || in_if.ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.stream_byte <= byte_q.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // beat monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_beats++;
                if (frame_q.size() == 0) begin
                    $error("unexpected beat: byte %0h valid %0b last %0b err %0d",
                           out_if.payload_byte, out_if.payload_valid,
                           out_if.frame_last, out_if.error_code);
                    n_fail++;
                end else begin
                    got_exp = frame_q.pop_front();
                    if (out_if.payload_byte !== got_exp.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               got_exp.payload_byte, out_if.payload_byte);
                        n_fail++;
                    end
                    if (out_if.payload_valid !== got_exp.payload_valid) begin
                        $error("payload_valid: expected %0b, got %0b",
                               got_exp.payload_valid, out_if.payload_valid);
                        n_fail++;
                    end
                    if (out_if.frame_last !== got_exp.frame_last) begin
                        $error("frame_last: expected %0b, got %0b",
                               got_exp.frame_last, out_if.frame_last);
                        n_fail++;
                    end
                    if (out_if.error_code !== got_exp.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               got_exp.error_code, out_if.error_code);
                        n_fail++;
                    end
                    if (got_exp.frame_last) n_frames++;
                    if (got_exp.error_code == lpfe_pkg::ERR_NONDIGIT) n_digit_err++;
                    if (got_exp.error_code == lpfe_pkg::ERR_TOO_LONG) n_len_err++;
                end
            end
            if (hold_rx) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_length(input int len);
        int scale;
        scale = 1;
        for (int i = 1; i < lpfe_pkg::LENGTH_DIGITS; i++) scale *= 10;
        for (int i = 0; i < lpfe_pkg::LENGTH_DIGITS; i++) begin
            byte_q.push_back(ASCII_ZERO + lpfe_pkg::t_byte'((len / scale) % 10));
            scale /= 10;
        end
    endtask

    task automatic push_frame(input int len);
        byte_q.push_back(head_cfg);
        push_length(len);
        repeat (len) byte_q.push_back(lpfe_pkg::t_byte'($urandom_range(255)));
    endtask

    task automatic queue_random(input int n_items);
        int              added;
        int              prev;
        int              r;
        lpfe_pkg::t_byte b;
        added = 0;
        while (added < n_items) begin
            prev = byte_q.size();
            r = $urandom_range(99);
            if (r < 6) begin
                repeat ($urandom_range(1, 4))
                    byte_q.push_back(lpfe_pkg::t_byte'($urandom_range(255)));
            end else if (r < 14) begin
                byte_q.push_back(head_cfg);
                repeat ($urandom_range(lpfe_pkg::LENGTH_DIGITS - 1))
                    byte_q.push_back(ASCII_ZERO + lpfe_pkg::t_byte'($urandom_range(9)));
                do b = lpfe_pkg::t_byte'($urandom_range(255));
                while (b >= ASCII_ZERO && b <= ASCII_NINE);
                byte_q.push_back(b);
            end else if (r < 20) begin
                byte_q.push_back(head_cfg);
                push_length($urandom_range(lpfe_pkg::MAX_PAYLOAD + 1, 9999));
            end else if (r < 25) begin
                push_frame(0);
            end else if (r < 28) begin
                push_frame($urandom_range(17, 128));
            end else begin
                push_frame($urandom_range(1, 16));
            end
            added += byte_q.size() - prev;
        end
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || in_if.valid || frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_head(input lpfe_pkg::t_byte v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        head_cfg = v;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        in_if.valid = 1'b0;
        in_if.stream_byte = '0;
        out_if.ready = 1'b0;
        hold_rx = 1'b0;
        src_idle_pct = 7;
        snk_idle_pct = 47;
        pp = PH_HUNT;
        dig_cnt = '0;
        len_acc = '0;
        left = '0;
        head_cfg = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_head(8'hFF);
        byte_q.push_back(8'h00);
        byte_q.push_back(head_cfg);
        byte_q.push_back(ASCII_ZERO - 8'd1);
        // head byte where a digit belongs: error, not a restart
        byte_q.push_back(head_cfg);
        byte_q.push_back(head_cfg);
        byte_q.push_back(head_cfg);
        byte_q.push_back(ASCII_ZERO + 8'd5);
        byte_q.push_back(ASCII_NINE + 8'd1);
        push_frame(0);
        byte_q.push_back(head_cfg);
        push_length(lpfe_pkg::MAX_PAYLOAD + 1);
        byte_q.push_back(head_cfg);
        push_length(2);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        queue_random(RAND_ITEMS);
        drain();

        src_idle_pct <= 47;
        snk_idle_pct <= 7;
        write_head(8'h00);
        queue_random(RAND_ITEMS);
        drain();

        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        last_head = lpfe_pkg::t_byte'($urandom_range(255));
        write_head(last_head);
        push_frame(lpfe_pkg::MAX_PAYLOAD);
        push_frame(3);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
        queue_random(RAND_ITEMS);
        drain();

        $display("Checked %0d beats: %0d frames closed, %0d bad-digit, %0d over-length.",
                 n_beats, n_frames, n_digit_err, n_len_err);
        $display("Head bytes ff, 00, %02h; stalls on both sides and a %0d-cycle sink hold-off.",
                 last_head, HOLD_CYCLES);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/lpfe_pkg.sv
design/lpfe_byte_if.sv
design/lpfe_frame_if.sv
design/lpfe_cfg_if.sv
design/lpfe_in_stage.sv
design/lpfe_parser.sv
design/lpfe_out_stage.sv
design/length_prefixed_frame_extractor_core.sv
test/tb_length_prefixed_frame_extractor_core.sv
